FILE: hw/rtl/gas_sensor_ppm_estimator_macros.svh
// Assertion helpers for the checker file of this block.
// Every macro samples on the rising edge of clock.
`ifndef GAS_SENSOR_PPM_ESTIMATOR_MACROS_SVH
`define GAS_SENSOR_PPM_ESTIMATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define GSPE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define GSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset was seen high.
`define GSPE_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/gspe_pkg.sv
`default_nettype none

package gspe_pkg;

   // Converter resolution and the fixed field widths.
   localparam int ADC_BITS = 12;
   localparam int ADC_FS   = (1 << ADC_BITS) - 1;
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 20;
   localparam int COUNT_W  = 8;
   localparam int RS_W     = 20;
   localparam int RATIO_W  = 24;
   localparam int PPM_W    = 24;
   localparam int CSR_W    = 24;

   // Divisor width of the serial unit: the averaging divisor n*FS*4096 is the widest.
   localparam int DEN_W = COUNT_W + ADC_BITS + 12;
   localparam int OPB_W = (DEN_W > 32) ? DEN_W : 32;

   localparam int SUM_MAX      = (1 << SUM_W) - 1;
   localparam int RS_NEAR_ZERO = 1000000;
   localparam int OUT24_MAX    = (1 << 24) - 1;
   localparam int LOG2_TEN_Q16 = 217706;
   localparam int UV_FULL      = 3300000;
   localparam int VOLT_LOW     = 100;
   localparam int E_SAT        = 24 * 65536;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_SAMPLES   = 3'd0,
      CSR_LOAD_RES  = 3'd1,
      CSR_SUPPLY    = 3'd2,
      CSR_GAIN      = 3'd3,
      CSR_CLEAN_RES = 3'd4,
      CSR_SLOPE     = 3'd5,
      CSR_INTERCEPT = 3'd6
   } csr_index_type;

   // Command to the serial multiply and divide unit.
   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_cmd_type;

   // Floor square root, one result bit per pass.
   function automatic logic [63:0] isqrt_f(input logic [63:0] v);
      logic [63:0] rem_v;
      logic [63:0] res_v;
      logic [63:0] bit_v;
      rem_v = v;
      res_v = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (rem_v >= res_v + bit_v) begin
            rem_v = rem_v - (res_v + bit_v);
            res_v = (res_v >> 1) + bit_v;
         end else begin
            res_v = res_v >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res_v;
   endfunction

   // Q30 factor 2^(2^-idx), each one the floor square root of the one before.
   function automatic logic [31:0] pow_root_f(input int idx);
      logic [63:0] root_v;
      root_v = 64'h0000_0000_8000_0000;
      for (int i = 1; i <= idx; i++) begin
         root_v = isqrt_f(root_v << 30);
      end
      return root_v[31:0];
   endfunction

   localparam logic [31:0] POW_ROOT [16] = '{
      pow_root_f(1),  pow_root_f(2),  pow_root_f(3),  pow_root_f(4),
      pow_root_f(5),  pow_root_f(6),  pow_root_f(7),  pow_root_f(8),
      pow_root_f(9),  pow_root_f(10), pow_root_f(11), pow_root_f(12),
      pow_root_f(13), pow_root_f(14), pow_root_f(15), pow_root_f(16)
   };

endpackage

`default_nettype wire

FILE: hw/rtl/gspe_if.sv
`default_nettype none

// Sample channel: one converter sample per transaction.
interface gspe_req_if;
   import gspe_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

// Reading channel: one finished reading per transaction.
interface gspe_rsp_if;
   import gspe_pkg::*;
   logic               valid;
   logic               ready;
   logic [RS_W-1:0]    sensor_resistance;
   logic [RATIO_W-1:0] resistance_ratio;
   logic [PPM_W-1:0]   gas_ppm;
   logic               saturated;
   modport source (output valid, output sensor_resistance, output resistance_ratio,
                   output gas_ppm, output saturated, input ready);
   modport sink (input valid, input sensor_resistance, input resistance_ratio,
                 input gas_ppm, input saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gspe_mdu.sv
`default_nettype none

// Serial multiply and divide unit. A multiply walks the multiplier one bit per
// cycle; a divide is restoring, one quotient bit per cycle.
module gspe_mdu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gspe_pkg::mdu_cmd_type cmd,
   input  wire logic [63:0]          opa,
   input  wire logic [gspe_pkg::OPB_W-1:0] opb,
   output logic [63:0]               result,
   output logic                      done
);
   import gspe_pkg::*;

   localparam logic [5:0] MUL_LAST = 6'(OPB_W - 1);
   localparam logic [5:0] DIV_LAST = 6'd63;

   logic             busy_ff;
   logic             done_ff;
   mdu_op_type       op_ff;
   logic [5:0]       cnt_ff;
   logic [63:0]      acc_ff;
   logic [63:0]      a_ff;
   logic [OPB_W-1:0] b_ff;
   logic [OPB_W-1:0] rem_ff;

   logic [OPB_W:0]   rem_sh;
   logic             q_bit;
   logic [OPB_W-1:0] rem_in;
   logic             last_step;

   // One restoring divide step: shift in the next numerator bit, try the subtract.
   always_comb begin
      rem_sh = {rem_ff, acc_ff[63]};
      q_bit  = (rem_sh >= {1'b0, b_ff});
      rem_in = q_bit ? OPB_W'(rem_sh - {1'b0, b_ff}) : rem_sh[OPB_W-1:0];
      last_step = (op_ff == MDU_MUL) ? (cnt_ff == MUL_LAST) : (cnt_ff == DIV_LAST);
   end

   // Control: busy flag, step count and the done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: shift-add product or shifting quotient.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         b_ff   <= opb;
         rem_ff <= '0;
         a_ff   <= opa;
         acc_ff <= (cmd.op == MDU_MUL) ? 64'd0 : opa;
      end else if (busy_ff) begin
         if (op_ff == MDU_MUL) begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff <= a_ff << 1;
            b_ff <= b_ff >> 1;
         end else begin
            rem_ff <= rem_in;
            acc_ff <= {acc_ff[62:0], q_bit};
         end
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gas_sensor_ppm_estimator.sv
// Gas sensor concentration estimator, power-law sensor curve.
// req_ch carries one converter sample per transaction; rsp_ch carries one
// reading (Rs in ohms, Rs/Ro in Q8.16, ppm, saturation flag) per transaction.
// Registers are written through csr_we / csr_index / csr_wdata; the user must
// write them only while idle, as the block does not enforce it. A sample that
// does not complete a reading is taken and ready stays high. The sample that
// completes a reading starts the arithmetic, and ready stays low until the
// reading is placed in the output register. The steps, in order: two multiplies
// and a divide for the voltage, the fixed-case check, a multiply and a divide
// for Rs, the Ro check and a divide for the ratio, repeated squaring for the
// logarithm, the exponent, root multiplies for the power of two and the
// hand-off. All multiplies and divides but the exponent products run through
// one serial multiply/divide unit that handles one bit per cycle.
// Reset restores the register defaults and clears the running sum and count.
// A stalled receiver holds the reading in the output register; samples are still
// accepted until the next reading completes; it then waits for the slot, ready low.
`default_nettype none

module gas_sensor_ppm_estimator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   gspe_req_if.sink                        req_ch,
   gspe_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [gspe_pkg::CSR_W-1:0] csr_wdata
);
   import gspe_pkg::*;

   typedef enum logic [4:0] {
      ST_ACCUM,
      ST_VOLT_MUL1,
      ST_VOLT_MUL2,
      ST_VOLT_DIV,
      ST_RS_CHECK,
      ST_RS_MUL,
      ST_RS_DIV,
      ST_RATIO,
      ST_RATIO_DIV,
      ST_LOG_INIT,
      ST_LOG_SQ,
      ST_EXP_MUL,
      ST_EXP_SUM,
      ST_POW_SEL,
      ST_POW_MUL,
      ST_POW_END,
      ST_OUTPUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [7:0]  spr_ff;
   logic [19:0] load_res_ff;
   logic [12:0] supply_ff;
   logic [15:0] gain_ff;
   logic [23:0] clean_res_ff;
   logic [15:0] slope_ff;
   logic [15:0] intercept_ff;

   // Accumulation and per-reading registers.
   logic [SUM_W-1:0]   sum_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SUM_W-1:0]   rd_sum_ff;
   logic [COUNT_W-1:0] rd_n_ff;
   logic [63:0]        work_ff;
   logic [25:0]        volt_ff;
   logic [RS_W-1:0]    rs_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic [PPM_W-1:0]   ppm_ff;
   logic               sat_ff;
   logic [31:0]        m_ff;
   logic [15:0]        frac_ff;
   logic [4:0]         p_ff;
   logic [3:0]         iter_ff;
   logic signed [37:0] prod_a_ff;
   logic signed [37:0] prod_b_ff;
   logic [4:0]         k_ff;
   logic [15:0]        f_ff;
   logic [31:0]        acc_ff;
   logic [3:0]         idx_ff;
   logic               start_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [RS_W-1:0]    rsp_rs_ff;
   logic [RATIO_W-1:0] rsp_ratio_ff;
   logic [PPM_W-1:0]   rsp_ppm_ff;
   logic               rsp_sat_ff;

   // Combinational helpers.
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_in;
   logic [COUNT_W:0]   n_in;
   logic [COUNT_W:0]   target;
   logic               reading_done;
   logic [OPB_W-1:0]   den;
   logic [22:0]        vcc;
   logic [4:0]         p_enc;
   logic [31:0]        m_init;
   logic [31:0]        sq32;
   logic signed [21:0] l_val;
   logic signed [15:0] slope_sig;
   logic signed [15:0] intercept_sig;
   logic signed [37:0] prod_a_in;
   logic signed [37:0] prod_b_in;
   logic signed [38:0] e_full;
   logic signed [26:0] e_val;
   logic [31:0]        ppm_shift;
   logic               out_free;

   mdu_cmd_type        mdu_cmd;
   logic [63:0]        mdu_a;
   logic [OPB_W-1:0]   mdu_b;
   logic [63:0]        mdu_result;
   logic               mdu_done;

   // Running sum with saturation, and the end-of-reading test.
   always_comb begin
      sum_wide = {1'b0, sum_ff} +
                 (SUM_W + 1)'(SUM_W'(req_ch.adc_sample) & SUM_W'(ADC_FS));
      sum_in   = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : sum_wide[SUM_W-1:0];
      n_in     = {1'b0, count_ff} + 9'd1;
      target   = (spr_ff == 8'd0) ? 9'd1 : {1'b0, spr_ff};
      reading_done = (n_in >= target);
   end

   // Averaging divisor and supply in microvolts.
   assign den = (OPB_W'(rd_n_ff) * OPB_W'(ADC_FS)) << 12;
   assign vcc = 23'(supply_ff) * 23'd1000;

   // Top set bit of the ratio and the normalized Q30 mantissa.
   always_comb begin
      p_enc = '0;
      for (int j = 1; j < RATIO_W; j++) begin
         if (ratio_ff[j]) begin
            p_enc = 5'(j);
         end
      end
      m_init = {8'b0, ratio_ff} << (5'd30 - p_enc);
   end

   assign sq32 = mdu_result[61:30];

   // Exponent E = floor((slope*L + intercept*log2(10)) / 4096) in Q16.
   assign l_val         = {6'({1'b0, p_ff}) - 6'd16, frac_ff};
   assign slope_sig     = slope_ff;
   assign intercept_sig = intercept_ff;
   assign prod_a_in     = 38'(slope_sig) * 38'(l_val);
   assign prod_b_in     = 38'(intercept_sig) * 38'(LOG2_TEN_Q16);
   assign e_full        = 39'(prod_a_ff) + 39'(prod_b_ff);
   assign e_val         = 27'(e_full >>> 12);

   assign ppm_shift = acc_ff >> (5'd30 - k_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Operands for the serial unit, chosen by the step in progress.
   always_comb begin
      mdu_a = '0;
      mdu_b = '0;
      mdu_cmd.start = start_ff;
      mdu_cmd.op    = MDU_MUL;
      case (state_ff)
         ST_VOLT_MUL1: begin
            mdu_a = 64'(rd_sum_ff);
            mdu_b = OPB_W'(UV_FULL);
         end
         ST_VOLT_MUL2: begin
            mdu_a = work_ff;
            mdu_b = OPB_W'(gain_ff);
         end
         ST_VOLT_DIV: begin
            mdu_a = work_ff;
            mdu_b = den;
            mdu_cmd.op = MDU_DIV;
         end
         ST_RS_MUL: begin
            mdu_a = 64'(load_res_ff);
            mdu_b = OPB_W'(vcc - volt_ff[22:0]);
         end
         ST_RS_DIV: begin
            mdu_a = work_ff;
            mdu_b = OPB_W'(volt_ff);
            mdu_cmd.op = MDU_DIV;
         end
         ST_RATIO_DIV: begin
            mdu_a = 64'(rs_ff) << 16;
            mdu_b = OPB_W'(clean_res_ff);
            mdu_cmd.op = MDU_DIV;
         end
         ST_LOG_SQ: begin
            mdu_a = 64'(m_ff);
            mdu_b = OPB_W'(m_ff);
         end
         ST_POW_MUL: begin
            mdu_a = 64'(acc_ff);
            mdu_b = OPB_W'(POW_ROOT[idx_ff]);
         end
         default: begin
            mdu_a = '0;
         end
      endcase
   end

   gspe_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mdu_cmd),
      .opa    (mdu_a),
      .opb    (mdu_b),
      .result (mdu_result),
      .done   (mdu_done)
   );

   // Sequencer, configuration registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         spr_ff       <= 8'd10;
         load_res_ff  <= 20'd10000;
         supply_ff    <= 13'd5000;
         gain_ff      <= 16'd4096;
         clean_res_ff <= '0;
         slope_ff     <= 16'(-5898);
         intercept_ff <= 16'd9421;
      end else begin
         start_ff <= 1'b0;

         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES:   spr_ff       <= csr_wdata[7:0];
               CSR_LOAD_RES:  load_res_ff  <= csr_wdata[19:0];
               CSR_SUPPLY:    supply_ff    <= csr_wdata[12:0];
               CSR_GAIN:      gain_ff      <= csr_wdata[15:0];
               CSR_CLEAN_RES: clean_res_ff <= csr_wdata[23:0];
               CSR_SLOPE:     slope_ff     <= csr_wdata[15:0];
               CSR_INTERCEPT: intercept_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_ACCUM: begin
               if (req_ch.valid) begin
                  if (reading_done) begin
                     sum_ff    <= '0;
                     count_ff  <= '0;
                     rd_sum_ff <= sum_in;
                     rd_n_ff   <= n_in[COUNT_W-1:0];
                     sat_ff    <= 1'b0;
                     ppm_ff    <= '0;
                     start_ff  <= 1'b1;
                     state_ff  <= ST_VOLT_MUL1;
                  end else begin
                     sum_ff   <= sum_in;
                     count_ff <= n_in[COUNT_W-1:0];
                  end
               end
            end
            ST_VOLT_MUL1: begin
               if (mdu_done) begin
                  work_ff  <= mdu_result;
                  start_ff <= 1'b1;
                  state_ff <= ST_VOLT_MUL2;
               end
            end
            ST_VOLT_MUL2: begin
               if (mdu_done) begin
                  work_ff  <= mdu_result;
                  start_ff <= 1'b1;
                  state_ff <= ST_VOLT_DIV;
               end
            end
            ST_VOLT_DIV: begin
               if (mdu_done) begin
                  volt_ff  <= mdu_result[25:0];
                  state_ff <= ST_RS_CHECK;
               end
            end
            // Near-zero voltage and voltage at or above the supply are fixed cases.
            ST_RS_CHECK: begin
               if (volt_ff <= 26'(VOLT_LOW)) begin
                  rs_ff    <= RS_W'(RS_NEAR_ZERO);
                  state_ff <= ST_RATIO;
               end else if (volt_ff >= 26'(vcc)) begin
                  rs_ff    <= '0;
                  state_ff <= ST_RATIO;
               end else begin
                  start_ff <= 1'b1;
                  state_ff <= ST_RS_MUL;
               end
            end
            ST_RS_MUL: begin
               if (mdu_done) begin
                  work_ff  <= mdu_result;
                  start_ff <= 1'b1;
                  state_ff <= ST_RS_DIV;
               end
            end
            ST_RS_DIV: begin
               if (mdu_done) begin
                  rs_ff <= (mdu_result > 64'(RS_NEAR_ZERO)) ? RS_W'(RS_NEAR_ZERO)
                                                           : mdu_result[RS_W-1:0];
                  state_ff <= ST_RATIO;
               end
            end
            // Without a calibrated Ro the ratio and ppm stay zero.
            ST_RATIO: begin
               if (clean_res_ff == 24'd0) begin
                  ratio_ff <= '0;
                  state_ff <= ST_OUTPUT;
               end else begin
                  start_ff <= 1'b1;
                  state_ff <= ST_RATIO_DIV;
               end
            end
            ST_RATIO_DIV: begin
               if (mdu_done) begin
                  if (mdu_result > 64'(OUT24_MAX)) begin
                     ratio_ff <= RATIO_W'(OUT24_MAX);
                     sat_ff   <= 1'b1;
                     state_ff <= ST_LOG_INIT;
                  end else if (mdu_result == 64'd0) begin
                     ratio_ff <= '0;
                     state_ff <= ST_OUTPUT;
                  end else begin
                     ratio_ff <= mdu_result[RATIO_W-1:0];
                     state_ff <= ST_LOG_INIT;
                  end
               end
            end
            ST_LOG_INIT: begin
               p_ff     <= p_enc;
               m_ff     <= m_init;
               frac_ff  <= '0;
               iter_ff  <= '0;
               start_ff <= 1'b1;
               state_ff <= ST_LOG_SQ;
            end
            // Each squaring of the mantissa yields one fraction bit of log2.
            ST_LOG_SQ: begin
               if (mdu_done) begin
                  if (sq32[31]) begin
                     m_ff    <= sq32 >> 1;
                     frac_ff <= {frac_ff[14:0], 1'b1};
                  end else begin
                     m_ff    <= sq32;
                     frac_ff <= {frac_ff[14:0], 1'b0};
                  end
                  iter_ff <= iter_ff + 4'd1;
                  if (iter_ff == 4'd15) begin
                     state_ff <= ST_EXP_MUL;
                  end else begin
                     start_ff <= 1'b1;
                  end
               end
            end
            ST_EXP_MUL: begin
               prod_a_ff <= prod_a_in;
               prod_b_ff <= prod_b_in;
               state_ff  <= ST_EXP_SUM;
            end
            ST_EXP_SUM: begin
               if (e_val >= 27'(E_SAT)) begin
                  ppm_ff   <= PPM_W'(OUT24_MAX);
                  sat_ff   <= 1'b1;
                  state_ff <= ST_OUTPUT;
               end else if (e_val[26]) begin
                  ppm_ff   <= '0;
                  state_ff <= ST_OUTPUT;
               end else begin
                  k_ff     <= e_val[20:16];
                  f_ff     <= e_val[15:0];
                  acc_ff   <= 32'h4000_0000;
                  idx_ff   <= '0;
                  state_ff <= ST_POW_SEL;
               end
            end
            // Fraction bits are taken from the top; a set bit multiplies in its root.
            ST_POW_SEL: begin
               if (f_ff[15]) begin
                  start_ff <= 1'b1;
                  state_ff <= ST_POW_MUL;
               end else begin
                  f_ff   <= f_ff << 1;
                  idx_ff <= idx_ff + 4'd1;
                  if (idx_ff == 4'd15) begin
                     state_ff <= ST_POW_END;
                  end
               end
            end
            ST_POW_MUL: begin
               if (mdu_done) begin
                  acc_ff <= sq32;
                  f_ff   <= f_ff << 1;
                  idx_ff <= idx_ff + 4'd1;
                  state_ff <= (idx_ff == 4'd15) ? ST_POW_END : ST_POW_SEL;
               end
            end
            ST_POW_END: begin
               ppm_ff <= (ppm_shift > 32'(OUT24_MAX)) ? PPM_W'(OUT24_MAX)
                                                      : ppm_shift[PPM_W-1:0];
               state_ff <= ST_OUTPUT;
            end
            // Hand the reading to the output register once it is free.
            ST_OUTPUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_rs_ff    <= rs_ff;
                  rsp_ratio_ff <= ratio_ff;
                  rsp_ppm_ff   <= ppm_ff;
                  rsp_sat_ff   <= sat_ff;
                  state_ff     <= ST_ACCUM;
               end
            end
            default: begin
               state_ff <= ST_ACCUM;
            end
         endcase
      end
   end

   assign req_ch.ready             = (state_ff == ST_ACCUM);
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.sensor_resistance = rsp_rs_ff;
   assign rsp_ch.resistance_ratio  = rsp_ratio_ff;
   assign rsp_ch.gas_ppm           = rsp_ppm_ff;
   assign rsp_ch.saturated         = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gspe_checker.sv
`default_nettype none
`include "gas_sensor_ppm_estimator_macros.svh"

// Checks on the reading channel as seen at the top-level ports.
module gspe_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [gspe_pkg::RS_W-1:0]    sensor_resistance,
   input wire logic [gspe_pkg::RATIO_W-1:0] resistance_ratio,
   input wire logic [gspe_pkg::PPM_W-1:0]   gas_ppm,
   input wire logic                         saturated
);
   import gspe_pkg::*;

   // No reading is offered right after reset.
   `GSPE_ASSERT_AFTER_RESET(a_idle_after_reset, !rsp_valid, "reading offered after reset")

   // A stalled reading keeps its value.
   `GSPE_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(gas_ppm) && $stable(resistance_ratio) && $stable(sensor_resistance), "stalled reading changed")

   // Rs never exceeds the near-zero-voltage value.
   `GSPE_ASSERT_IMP(a_rs_bound, rsp_valid, sensor_resistance <= RS_W'(RS_NEAR_ZERO), "Rs out of range")

   // The saturation flag only comes with a clamped ratio or ppm.
   `GSPE_ASSERT_IMP(a_sat_clamped, rsp_valid && saturated, resistance_ratio == RATIO_W'(OUT24_MAX) || gas_ppm == PPM_W'(OUT24_MAX), "flag without clamp")

   // A zero ratio gives zero ppm.
   `GSPE_ASSERT_IMP(a_zero_ratio, rsp_valid && resistance_ratio == '0, gas_ppm == '0, "ppm without ratio")

endmodule

bind gas_sensor_ppm_estimator gspe_checker u_gspe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .sensor_resistance (rsp_ch.sensor_resistance),
   .resistance_ratio  (rsp_ch.resistance_ratio),
   .gas_ppm           (rsp_ch.gas_ppm),
   .saturated         (rsp_ch.saturated)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import gspe_pkg::*;

   // Index past the end of the register list; writes to it must be ignored.
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int READING_LATENCY = 1400;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD = 3000;
   localparam int HOLD_AT_READING = 40;

   typedef struct packed {
      logic [RS_W-1:0]    rs;
      logic [RATIO_W-1:0] ratio;
      logic [PPM_W-1:0]   ppm;
      logic               sat;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   gspe_req_if req_ch();
   gspe_rsp_if rsp_ch();

   gas_sensor_ppm_estimator uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Register copies and accumulator state of the estimator model.
   logic [7:0]         spr_r;
   logic [19:0]        load_r;
   logic [12:0]        supply_r;
   logic [15:0]        gain_r;
   logic [23:0]        ro_r;
   logic signed [15:0] slope_r;
   logic signed [15:0] icpt_r;
   longint unsigned    acc_sum;
   longint unsigned    acc_count;

   logic [SAMPLE_W-1:0] sample_queue[$];
   reading_type         reading_queue[$];
   reading_type         next_reading;
   int snd_gap, rcv_gap, hold_left, idle_cycles;
   int snd_max = 0, rcv_max = 0;
   int errors = 0, samples_taken = 0, readings_seen = 0, phases = 0;
   bit hold_done = 0;

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned rem, res, b;
      rem = v;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > rem && b != 0) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Base-2 logarithm of a Q16 ratio, in signed Q16, by repeated squaring.
   function automatic longint ratio_log2(input longint unsigned x);
      int p;
      longint unsigned m;
      longint frac;
      p = 23;
      frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      m = x << (30 - p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(p - 16) * 65536 + frac;
   endfunction

   // Two to the power of a 16-bit fraction, in Q30.
   function automatic longint unsigned frac_exp2(input logic [15:0] f);
      longint unsigned root, acc;
      root = 64'h8000_0000;
      acc = 64'h4000_0000;
      for (int i = 1; i <= 16; i++) begin
         root = floor_sqrt(root << 30);
         if (f[16 - i]) acc = (acc * root) >> 30;
      end
      return acc;
   endfunction

   // Adds one sample; returns 1 with the reading when it completes one.
   function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] s,
                                            output reading_type r);
      longint unsigned target, sum, n, volt, vcc, rs, ratio, ppm;
      longint e;
      bit sat;
      target = (spr_r == 0) ? 1 : spr_r;
      sum = acc_sum + (s & ADC_FS);
      if (sum > SUM_MAX) sum = SUM_MAX;
      n = acc_count + 1;
      r = '0;
      if (n < target) begin
         acc_sum = sum;
         acc_count = n & 8'hFF;
         return 0;
      end
      acc_sum = 0;
      acc_count = 0;
      ratio = 0;
      ppm = 0;
      sat = 0;
      volt = (sum * UV_FULL * gain_r) / (n * ADC_FS * 4096);
      vcc = longint'(supply_r) * 1000;
      if (volt <= VOLT_LOW) rs = RS_NEAR_ZERO;
      else if (volt >= vcc) rs = 0;
      else begin
         rs = load_r * (vcc - volt) / volt;
         if (rs > RS_NEAR_ZERO) rs = RS_NEAR_ZERO;
      end
      if (ro_r != 0) begin
         ratio = (rs << 16) / ro_r;
         if (ratio > OUT24_MAX) begin
            ratio = OUT24_MAX;
            sat = 1;
         end
         if (ratio != 0) begin
            e = (longint'(slope_r) * ratio_log2(ratio) +
                 longint'(icpt_r) * LOG2_TEN_Q16) >>> 12;
            if (e >= E_SAT) begin
               ppm = OUT24_MAX;
               sat = 1;
            end else if (e >= 0) begin
               ppm = frac_exp2(e[15:0]) >> (30 - (e >> 16));
               if (ppm > OUT24_MAX) ppm = OUT24_MAX;
            end
         end
      end
      r.rs = rs[RS_W-1:0];
      r.ratio = ratio[RATIO_W-1:0];
      r.ppm = ppm[PPM_W-1:0];
      r.sat = sat;
      return 1;
   endfunction

   // Sample driver: one transaction per queued sample, random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.adc_sample <= '0;
         snd_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            samples_taken++;
            if (accumulate_sample(req_ch.adc_sample, next_reading))
               reading_queue.push_back(next_reading);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (snd_gap > 0) begin
               req_ch.valid <= 1'b0;
               snd_gap <= snd_gap - 1;
            end else if (sample_queue.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.adc_sample <= sample_queue.pop_front();
               snd_gap <= $urandom_range(0, snd_max);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Reading monitor: checks each transaction and applies receiver stalls.
   always @(posedge clock) begin
      reading_type want;
      int g;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rcv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            readings_seen++;
            if (reading_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected reading rs=%0d ratio=%0d ppm=%0d sat=%0d", $time,
                        rsp_ch.sensor_resistance, rsp_ch.resistance_ratio,
                        rsp_ch.gas_ppm, rsp_ch.saturated);
            end else begin
               want = reading_queue.pop_front();
               if (rsp_ch.sensor_resistance !== want.rs || rsp_ch.resistance_ratio !==
                   want.ratio || rsp_ch.gas_ppm !== want.ppm ||
                   rsp_ch.saturated !== want.sat) begin
                  errors++;
                  $display("%0t: mismatch expected rs=%0d ratio=%0d ppm=%0d sat=%0d",
                           $time, want.rs, want.ratio, want.ppm, want.sat);
                  $display("%0t:          actual   rs=%0d ratio=%0d ppm=%0d sat=%0d",
                           $time, rsp_ch.sensor_resistance, rsp_ch.resistance_ratio,
                           rsp_ch.gas_ppm, rsp_ch.saturated);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && readings_seen >= HOLD_AT_READING) begin
            // Long hold-off so that the block fills up and stalls samples.
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            g = $urandom_range(0, rcv_max);
            rcv_gap <= g;
            rsp_ch.ready <= (g == 0);
         end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            rsp_ch.ready <= (rcv_gap == 1);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("[gas_sensor_ppm_estimator] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      case (idx)
         CSR_SAMPLES:   spr_r = val[7:0];
         CSR_LOAD_RES:  load_r = val[19:0];
         CSR_SUPPLY:    supply_r = val[12:0];
         CSR_GAIN:      gain_r = val[15:0];
         CSR_CLEAN_RES: ro_r = val[23:0];
         CSR_SLOPE:     slope_r = val[15:0];
         CSR_INTERCEPT: icpt_r = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits for all samples and readings, then lets a last reading finish.
   task automatic drain();
      while (sample_queue.size() > 0 || req_ch.valid || reading_queue.size() > 0)
         @(posedge clock);
      repeat (READING_LATENCY) @(posedge clock);
      phases++;
   endtask

   task automatic queue_range(input int count, input int lo, input int hi);
      for (int i = 0; i < count; i++) sample_queue.push_back($urandom_range(lo, hi));
   endtask

   initial begin
      int lo, hi, n;
      req_ch.valid = 1'b0;
      req_ch.adc_sample = '0;
      rsp_ch.ready = 1'b0;
      spr_r = 10; load_r = 10000; supply_r = 5000; gain_r = 4096;
      ro_r = 0; slope_r = -5898; icpt_r = 9421;
      acc_sum = 0; acc_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: clean-air resistance zero gives zero ratio and ppm.
      for (int i = 0; i < 10; i++) sample_queue.push_back(i[0] ? 12'hFFF : 12'h000);
      drain();
      // Zero samples per reading acts as one; a tiny Ro saturates the ratio.
      write_reg(CSR_SAMPLES, 0);
      write_reg(CSR_CLEAN_RES, 1);
      sample_queue = '{12'd0, 12'd4095, 12'd2048};
      drain();
      // Zero supply pushes the voltage above it, so Rs is zero.
      write_reg(CSR_SUPPLY, 0);
      write_reg(CSR_CLEAN_RES, 10000);
      sample_queue.push_back(12'd2000);
      drain();
      // Huge intercept saturates ppm; the most negative one drives it to zero.
      write_reg(CSR_SUPPLY, 5000);
      write_reg(CSR_SLOPE, 0);
      write_reg(CSR_INTERCEPT, 16'h7FFF);
      sample_queue.push_back(12'd1500);
      drain();
      write_reg(CSR_INTERCEPT, 16'h8000);
      sample_queue.push_back(12'd1500);
      drain();
      // Usual curve with extreme gain and load resistor.
      write_reg(CSR_SLOPE, 16'hE8F6);
      write_reg(CSR_INTERCEPT, 9421);
      write_reg(CSR_CLEAN_RES, 20000);
      write_reg(CSR_GAIN, 16'hFFFF);
      write_reg(CSR_LOAD_RES, 20'hFFFFF);
      sample_queue = '{12'd1, 12'd100, 12'd3000};
      drain();
      // Write past the register list, then lower the count in mid-reading.
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      write_reg(CSR_GAIN, 4096);
      write_reg(CSR_LOAD_RES, 10000);
      write_reg(CSR_SAMPLES, 3);
      sample_queue = '{12'd1000, 12'd1200};
      drain();
      write_reg(CSR_SAMPLES, 1);
      sample_queue.push_back(12'd800);
      drain();

      // Random phases, each with its own register setting and idling mode.
      for (int ph = 0; ph < 30; ph++) begin
         snd_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
         rcv_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
         n = $urandom_range(40, 80);
         if (ph == 7) begin
            write_reg(CSR_SAMPLES, 255);
            n = 255;
         end else
            write_reg(CSR_SAMPLES, $urandom_range(0, 12));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_LOAD_RES, 20'hFFFFF);
            1: write_reg(CSR_LOAD_RES, $urandom_range(0, 100));
            default: write_reg(CSR_LOAD_RES, $urandom_range(1000, 100000));
         endcase
         write_reg(CSR_SUPPLY, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                          : $urandom_range(3000, 6000));
         write_reg(CSR_GAIN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(2048, 12288));
         case ($urandom_range(0, 4))
            0: write_reg(CSR_CLEAN_RES, 0);
            1: write_reg(CSR_CLEAN_RES, $urandom_range(0, 24'hFFFFFF));
            2: write_reg(CSR_CLEAN_RES, $urandom_range(1, 65535));
            default: write_reg(CSR_CLEAN_RES, $urandom_range(2000, 60000));
         endcase
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_SLOPE, $urandom_range(0, 65535));
            write_reg(CSR_INTERCEPT, $urandom_range(0, 65535));
         end else begin
            write_reg(CSR_SLOPE, 16'(-$urandom_range(2000, 9000)));
            write_reg(CSR_INTERCEPT, $urandom_range(2000, 20000));
         end
         if ($urandom_range(0, 1) == 0) begin
            lo = 0;
            hi = 4095;
         end else begin
            lo = $urandom_range(0, 4095);
            hi = $urandom_range(lo, 4095);
         end
         queue_range(n, lo, hi);
         drain();
      end

      $display("Covered %0d samples and %0d readings over %0d register settings.",
               samples_taken, readings_seen, phases);
      $display("Mismatches found: %0d.", errors);
      if (errors == 0) begin
         $display("[gas_sensor_ppm_estimator] OK");
      end else begin
         $display("[gas_sensor_ppm_estimator] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gspe_pkg.sv
hw/rtl/gspe_if.sv
hw/rtl/gspe_mdu.sv
hw/rtl/gas_sensor_ppm_estimator.sv
hw/rtl/gspe_checker.sv
test/testbench.sv
